FILE: rtl/sdas_pkg.sv
// Shared types, constants and BCD helper functions for the signed decimal
// add / subtract / compare unit. No dependencies.
package sdas_pkg;

	// Number geometry
	localparam int NIBBLES   = 16;
	localparam int DIGITS    = 16;
	localparam int BCD_W     = 4 * NIBBLES;
	localparam int IN_DATA_W  = 136;
	localparam int OUT_DATA_W = 72;

	// Operation codes carried in tuser
	typedef enum logic [1:0] {
		FUNC_ADD = 2'd0,
		FUNC_SUB = 2'd1,
		FUNC_CMP = 2'd2
	} func_t;

	// Compare outcome, two-bit signed
	localparam logic [1:0] ORD_LT = 2'b11;
	localparam logic [1:0] ORD_EQ = 2'b00;
	localparam logic [1:0] ORD_GT = 2'b01;

	typedef struct packed {
		logic [1:0]       func;
		logic [BCD_W-1:0] a_digits;
		logic             a_neg;
		logic [BCD_W-1:0] b_digits;
		logic             b_neg;
	} req_t;

	typedef struct packed {
		logic [BCD_W-1:0] result_digits;
		logic             result_neg;
		logic             overflow;
		logic [1:0]       order;
	} res_t;

	// Saturate out-of-range nibbles to 9, zero the digits above DIGITS
	function automatic logic [BCD_W-1:0] bcd_clamp(input logic [BCD_W-1:0] x);
		logic [BCD_W-1:0] y;
		logic [3:0]       d;
		y = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			d = x[4*i +: 4];
			if (i < DIGITS) begin
				y[4*i +: 4] = (d > 4'd9) ? 4'd9 : d;
			end
		end
		return y;
	endfunction

	// Nine's complement of a clamped value, per digit
	function automatic logic [BCD_W-1:0] bcd_nines(input logic [BCD_W-1:0] x);
		logic [BCD_W-1:0] y;
		y = '0;
		for (int i = 0; i < NIBBLES; i++) begin
			if (i < DIGITS) begin
				y[4*i +: 4] = 4'd9 - x[4*i +: 4];
			end
		end
		return y;
	endfunction

endpackage

FILE: rtl/sdas_dec_adder.sv
// Decimal (BCD) adder: one binary carry chain with the excess-6 correction.
// Depends on sdas_pkg.
module sdas_dec_adder (
	input  logic [sdas_pkg::BCD_W-1:0] x,
	input  logic [sdas_pkg::BCD_W-1:0] y,
	input  logic                       cin,
	output logic [sdas_pkg::BCD_W-1:0] sum,
	output logic                       cout
);

	logic [sdas_pkg::BCD_W-1:0] x6;
	logic [sdas_pkg::BCD_W:0]   raw;
	logic [sdas_pkg::BCD_W:0]   cvec;

	// Bias every digit of x by 6; digits are at most 9, so no carries here
	always_comb begin
		for (int i = 0; i < sdas_pkg::NIBBLES; i++) begin
			x6[4*i +: 4] = x[4*i +: 4] + 4'd6;
		end
	end

	// One binary add; the carry into each nibble is the decimal carry
	assign raw  = {1'b0, x6} + {1'b0, y} + {{sdas_pkg::BCD_W{1'b0}}, cin};
	assign cvec = raw ^ {1'b0, x6} ^ {1'b0, y};

	// Digits with no decimal carry out give the bias back
	always_comb begin
		sum = '0;
		for (int i = 0; i < sdas_pkg::NIBBLES; i++) begin
			if (i < sdas_pkg::DIGITS) begin
				sum[4*i +: 4] = cvec[4*i+4] ? raw[4*i +: 4] : (raw[4*i +: 4] - 4'd6);
			end
		end
	end

	assign cout = cvec[4*sdas_pkg::DIGITS];

endmodule

FILE: rtl/sdas_alu.sv
// Sign-magnitude add / subtract / compare datapath for one request.
// Depends on sdas_pkg and sdas_dec_adder.
module sdas_alu (
	input  sdas_pkg::req_t req,
	output sdas_pkg::res_t res
);

	logic [sdas_pkg::BCD_W-1:0] a_mag;
	logic [sdas_pkg::BCD_W-1:0] b_mag;
	logic [sdas_pkg::BCD_W-1:0] sum_ab;
	logic [sdas_pkg::BCD_W-1:0] diff_ab;
	logic [sdas_pkg::BCD_W-1:0] diff_ba;
	logic                       sum_cy;
	logic                       diff_ab_cy;
	logic                       diff_ba_cy;
	logic                       a_gt;
	logic                       a_lt;
	logic                       b_eff;
	logic [1:0]                 mag_ord;

	assign a_mag = sdas_pkg::bcd_clamp(req.a_digits);
	assign b_mag = sdas_pkg::bcd_clamp(req.b_digits);

	// Sum and both differences in parallel (ten's complement for the latter)
	sdas_dec_adder u_add (
		.x   (a_mag),
		.y   (b_mag),
		.cin (1'b0),
		.sum (sum_ab),
		.cout(sum_cy)
	);

	sdas_dec_adder u_sub_ab (
		.x   (a_mag),
		.y   (sdas_pkg::bcd_nines(b_mag)),
		.cin (1'b1),
		.sum (diff_ab),
		.cout(diff_ab_cy)
	);

	sdas_dec_adder u_sub_ba (
		.x   (b_mag),
		.y   (sdas_pkg::bcd_nines(a_mag)),
		.cin (1'b1),
		.sum (diff_ba),
		.cout(diff_ba_cy)
	);

	// A ten's complement subtract carries out when the minuend is not smaller;
	// both carries set means equal magnitudes
	assign a_gt = diff_ab_cy && !diff_ba_cy;
	assign a_lt = diff_ba_cy && !diff_ab_cy;
	assign mag_ord = a_gt ? sdas_pkg::ORD_GT : (a_lt ? sdas_pkg::ORD_LT : sdas_pkg::ORD_EQ);

	// Subtract is add with b's sign flipped
	assign b_eff = (sdas_pkg::func_t'(req.func) == sdas_pkg::FUNC_SUB) ? !req.b_neg : req.b_neg;

	// Result select
	always_comb begin
		res = '0;
		case (sdas_pkg::func_t'(req.func))
			sdas_pkg::FUNC_ADD, sdas_pkg::FUNC_SUB: begin
				if (req.a_neg == b_eff) begin
					res.result_digits = sum_ab;
					res.result_neg    = req.a_neg;
					res.overflow      = sum_cy;
				end else if (a_gt) begin
					res.result_digits = diff_ab;
					res.result_neg    = req.a_neg;
				end else if (a_lt) begin
					res.result_digits = diff_ba;
					res.result_neg    = b_eff;
				end
				// equal magnitudes, unlike signs: positive zero
			end
			sdas_pkg::FUNC_CMP: begin
				if (req.a_neg != req.b_neg) begin
					res.order = req.a_neg ? sdas_pkg::ORD_LT : sdas_pkg::ORD_GT;
				end else if (req.a_neg) begin
					res.order = 2'b00 - mag_ord;
				end else begin
					res.order = mag_ord;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

endmodule

FILE: rtl/signed_decimal_add_sub_compare_top.sv
// Top level of the signed decimal add / subtract / compare unit: stream
// ports, input register, result register. Depends on sdas_pkg and sdas_alu.

// Takes one request per clock and returns one result per request, in order.
// A request is held in an input register, goes through the decimal datapath
// (one excess-6 binary carry chain per adder, three adders side by side) and
// lands in a result register that drives the output ports. Throughput is
// one request per cycle as long as the output side takes results. The
// operation code rides in s_tuser
// (0 add, 1 subtract a minus b, 2 compare); code 3 gives an all-zero result.
// Magnitudes are 16-digit packed BCD, digit 0 in the low nibble; a digit
// above 9 is read as 9. Overflow flags a carry out of the top digit.
module signed_decimal_add_sub_compare_top (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	// [63:0] a_digits, [64] a_neg, [128:65] b_digits, [129] b_neg, rest zero
	input  logic [sdas_pkg::IN_DATA_W-1:0]  s_tdata,
	// [1:0] func
	input  logic [1:0]                      s_tuser,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// [63:0] result_digits, [64] result_neg, [65] overflow, [67:66] order
	output logic [sdas_pkg::OUT_DATA_W-1:0] m_tdata
);

	logic           valid_s1;
	logic           valid_s2;
	sdas_pkg::req_t req_s1;
	sdas_pkg::res_t res_s2;
	sdas_pkg::res_t res_next;
	logic           adv2;
	logic           take_in;

	// Handshake: each stage moves when the one after it has room
	assign adv2     = !valid_s2 || m_tready;
	assign s_tready = !valid_s1 || adv2;
	assign take_in  = s_tvalid && s_tready;

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (adv2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	// Input register
	always_ff @(posedge clk) begin
		if (take_in) begin
			req_s1.func     <= s_tuser;
			req_s1.a_digits <= s_tdata[63:0];
			req_s1.a_neg    <= s_tdata[64];
			req_s1.b_digits <= s_tdata[128:65];
			req_s1.b_neg    <= s_tdata[129];
		end
	end

	sdas_alu u_alu (
		.req(req_s1),
		.res(res_next)
	);

	// Result register
	always_ff @(posedge clk) begin
		if (adv2 && valid_s1) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'd0, res_s2.order, res_s2.overflow, res_s2.result_neg,
		res_s2.result_digits};

	// Overflow only comes from an add path, which never carries an order
	a_ovf_no_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.overflow |-> res_s2.order == sdas_pkg::ORD_EQ)
		else $error("overflow set on a compare result");

	// A compare outcome carries no magnitude and no sign
	a_cmp_clean: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.order != sdas_pkg::ORD_EQ |->
		res_s2.result_digits == '0 && !res_s2.result_neg)
		else $error("compare result has nonzero magnitude or sign");

	// An empty result register never blocks the input side
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s2 |-> s_tready)
		else $error("input stalled with empty result register");

	// A request in the input register moves on when the output has room
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && adv2 |=> valid_s2)
		else $error("request lost between stages");

endmodule
